@@ hdl/iepm_pkg.sv @@
`timescale 1ns / 1ps
package iepm_pkg;

  localparam int PageBytes = 16;
  localparam int PageIdxW  = 4;
  localparam int AddrW     = 13;
  localparam int MaxBytes  = 256;
  localparam int FillW     = 9;
  localparam int BufIdxW   = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_START_ERR   = 3'd1;
  localparam logic [2:0] ST_ADDR_NACK   = 3'd2;
  localparam logic [2:0] ST_RESTART_ERR = 3'd3;
  localparam logic [2:0] ST_READ_NACK   = 3'd4;
  localparam logic [2:0] ST_DATA_NACK   = 3'd5;

  localparam logic [1:0] CFG_DEV   = 2'd0;
  localparam logic [1:0] CFG_WWAIT = 2'd1;
  localparam logic [1:0] CFG_RWAIT = 2'd2;

  // One classified item travelling from the front part to the engine.
  typedef struct packed {
    op_t         op;
    logic        sda;
    logic [12:0] addr;
    logic [8:0]  count;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rvalid;
    logic [7:0] rbyte;
    logic       rlast;
    logic       done;
    logic [2:0] status;
    logic       busy;
  } res_t;

endpackage

@@ hdl/iepm_fifo.sv @@
`timescale 1ns / 1ps
module iepm_fifo
  import iepm_pkg::*;
#(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  // Two-entry queue; both entries are read at fixed places.
  logic [Width-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = rp_r ? mem_r[1] : mem_r[0];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      if (wp_r) mem_r[1] <= wdata;
      else mem_r[0] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, (wr && !full)} - {1'b0, (rd && !empty)};
    end
  end

endmodule

@@ hdl/iepm_engine.sv @@
`timescale 1ns / 1ps
module iepm_engine
  import iepm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [19:0] cfg_val,
  input  logic        it_valid,
  input  item_t       it,
  output logic        it_take,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_full
);

  typedef enum logic [4:0] {
    S_IDLE, S_R_START, S_R_DEVW, S_R_AH, S_R_AL, S_R_RESTART, S_R_DEVR,
    S_R_DATA, S_W_START, S_W_DEVW, S_W_AH, S_W_AL, S_W_DATA, S_STOP, S_WAIT,
    S_MERGE
  } state_t;

  typedef enum logic [1:0] {M_READ, M_PGRD, M_PGWR} mode_t;

  state_t      st_r;
  mode_t       mode_r;
  logic [3:0]  bc_r;
  logic        half_r;
  logic [7:0]  sh_r;
  logic [8:0]  left_r;
  logic [12:0] cur_r;
  logic [8:0]  fill_r;
  logic [3:0]  poff_r;
  logic [8:0]  src_r;
  logic [4:0]  xi_r;
  logic [2:0]  err_r;
  logic [19:0] wait_r;
  logic        scl_r, sda_r;
  logic [6:0]  dev_r;
  logic [19:0] wwait_r;
  logic [15:0] rwait_r;

  logic [7:0]  wbuf [MaxBytes];
  logic [7:0]  pbuf [PageBytes];
  logic [7:0]  wb_q_r;
  logic [4:0]  mrg_r;    // bytes still to merge in this page

  // The merge step reads the write buffer one byte a cycle through a registered
  // memory read; while it runs, no item is consumed.
  logic busy_int;
  assign busy_int = st_r == S_MERGE;
  logic rd_phase_r;  // 1 when wb_q_r holds the byte for merge
  assign it_take  = it_valid && !res_full && !busy_int;

  // While a byte is being stored, the next one is fetched.
  always_ff @(posedge clk) begin
    if (st_r == S_MERGE) wb_q_r <= wbuf[src_r[BufIdxW-1:0] + {7'd0, rd_phase_r}];
  end

  logic [7:0] devw;
  assign devw = {dev_r, 1'b0};

  always_ff @(posedge clk) begin
    state_t nst;
    logic [3:0] bc; logic hf; logic [7:0] sh;
    logic c, d, last, ev_ok, ev_bad, ev_byte;
    logic [8:0] left; logic [4:0] n; logic [12:0] a;
    logic [19:0] w;
    res_t r;
    if (!rst_n) begin
      st_r <= S_IDLE; mode_r <= M_READ; bc_r <= '0; half_r <= 1'b0; sh_r <= '0;
      left_r <= '0; cur_r <= '0; fill_r <= '0; poff_r <= '0; src_r <= '0;
      xi_r <= '0; err_r <= '0; wait_r <= '0; scl_r <= 1'b1; sda_r <= 1'b1;
      dev_r <= 7'd80; wwait_r <= 20'd100000; rwait_r <= 16'd200;
      res_valid <= 1'b0; mrg_r <= '0; rd_phase_r <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DEV:   dev_r <= cfg_val[6:0];
          CFG_WWAIT: wwait_r <= cfg_val;
          CFG_RWAIT: rwait_r <= cfg_val[15:0];
          default: ;
        endcase
      end
      if (st_r == S_MERGE) begin
        // Merge: first cycle fetches, following cycles store and fetch.
        if (rd_phase_r) begin
          pbuf[poff_r] <= wb_q_r;
          poff_r <= poff_r + 4'd1;
          mrg_r  <= mrg_r - 5'd1;
          if (mrg_r == 5'd1) begin
            st_r <= S_W_START; bc_r <= '0; half_r <= 1'b0; sh_r <= '0;
            rd_phase_r <= 1'b0;
          end else src_r <= src_r + 9'd1;
          if (mrg_r == 5'd1) src_r <= src_r + 9'd1;
        end else begin
          rd_phase_r <= 1'b1;
        end
      end else if (it_take) begin
        r = '0;
        nst = st_r; bc = bc_r; hf = half_r; sh = sh_r;
        c = scl_r; d = sda_r; left = left_r;
        ev_ok = 1'b0; ev_bad = 1'b0; ev_byte = 1'b0; last = 1'b0;
        n = '0; a = '0; w = '0;
        if (it.op != OP_TICK) begin
          if (st_r == S_IDLE) begin
            unique case (it.op)
              OP_PUSH: if (fill_r < 9'(MaxBytes)) begin
                wbuf[fill_r[BufIdxW-1:0]] <= it.data;
                fill_r <= fill_r + 9'd1;
              end
              OP_READ: if (it.count == '0) begin
                r.done = 1'b1;
              end else begin
                cur_r <= it.addr; left = (it.count > 9'(MaxBytes)) ? 9'(MaxBytes) : it.count;
                mode_r <= M_READ; err_r <= '0;
                nst = S_R_START; bc = '0; hf = 1'b0; sh = '0;
              end
              default: begin
                fill_r <= '0;
                if (it.count == '0) r.done = 1'b1;
                else begin
                  poff_r <= it.addr[3:0];
                  cur_r <= {it.addr[12:4], 4'd0};
                  left = (it.count > 9'(MaxBytes)) ? 9'(MaxBytes) : it.count;
                  src_r <= '0; mode_r <= M_PGRD; xi_r <= '0; err_r <= '0;
                  nst = S_R_START; bc = '0; hf = 1'b0; sh = '0;
                end
              end
            endcase
          end
        end else begin
          c = 1'b1; d = 1'b1;
          unique case (st_r)
            S_R_START, S_R_RESTART, S_W_START: begin
              case (bc_r)
                4'd0: begin c = 0; d = 1; bc = 4'd1; end
                4'd1: begin c = 1; d = 1; if (it.sda) bc = 4'd2; end
                4'd2: begin c = 1; d = 0; bc = 4'd3; end
                default: begin c = 0; d = 0; ev_ok = !it.sda; ev_bad = it.sda; end
              endcase
            end
            S_R_DEVW, S_R_AH, S_R_AL, S_R_DEVR, S_W_DEVW, S_W_AH, S_W_AL,
            S_W_DATA: begin
              if (!bc_r[3]) begin
                d = sh_r[3'd7 - bc_r[2:0]]; c = half_r;
                if (half_r) begin bc = bc_r + 4'd1; hf = 1'b0; end else hf = 1'b1;
              end else begin
                c = half_r; d = 1'b1;
                if (!half_r) hf = 1'b1;
                else begin ev_ok = !it.sda; ev_bad = it.sda; end
              end
            end
            S_R_DATA: begin
              last = (mode_r == M_READ) ? (left_r == '0) : xi_r[4];
              if (!bc_r[3]) begin
                c = half_r; d = 1'b1;
                if (half_r) begin
                  sh = {sh_r[6:0], it.sda}; bc = bc_r + 4'd1; hf = 1'b0;
                  ev_byte = bc_r == 4'd7;
                end else hf = 1'b1;
              end else begin
                c = half_r; d = last;
                if (!half_r) hf = 1'b1; else ev_ok = 1'b1;
              end
            end
            S_STOP: begin
              case (bc_r)
                4'd0: begin c = 0; d = 0; bc = 4'd1; end
                4'd1: begin c = 1; d = 0; bc = 4'd2; end
                default: ev_ok = 1'b1;
              endcase
            end
            S_WAIT: begin
              c = scl_r; d = sda_r;
              c = 1'b1; d = 1'b1;
              if (wait_r > 20'd1) wait_r <= wait_r - 20'd1;
              else begin wait_r <= '0; ev_ok = 1'b1; end
            end
            default: nst = S_IDLE;
          endcase
          // Transitions.
          unique case (st_r)
            S_R_START: if (ev_ok) begin nst = S_R_DEVW; bc = '0; hf = 0; sh = devw; end
                       else if (ev_bad) begin err_r <= ST_START_ERR; nst = S_STOP; bc = '0; hf = 0; sh = '0; end
            S_W_START: if (ev_ok) begin nst = S_W_DEVW; bc = '0; hf = 0; sh = devw; end
                       else if (ev_bad) begin err_r <= ST_START_ERR; nst = S_STOP; bc = '0; hf = 0; sh = '0; end
            S_R_DEVW: if (ev_ok) begin nst = S_R_AH; bc = '0; hf = 0; sh = {3'd0, cur_r[12:8]}; end
                      else if (ev_bad) begin err_r <= ST_ADDR_NACK; nst = S_STOP; bc = '0; hf = 0; sh = '0; end
            S_W_DEVW: if (ev_ok) begin nst = S_W_AH; bc = '0; hf = 0; sh = {3'd0, cur_r[12:8]}; end
                      else if (ev_bad) begin err_r <= ST_ADDR_NACK; nst = S_STOP; bc = '0; hf = 0; sh = '0; end
            S_R_AH: if (ev_ok || ev_bad) begin nst = S_R_AL; bc = '0; hf = 0; sh = cur_r[7:0]; end
            S_W_AH: if (ev_ok || ev_bad) begin nst = S_W_AL; bc = '0; hf = 0; sh = cur_r[7:0]; end
            S_R_AL: if (ev_ok || ev_bad) begin nst = S_R_RESTART; bc = '0; hf = 0; sh = '0; end
            S_W_AL: if (ev_ok || ev_bad) begin
              xi_r <= '0; nst = S_W_DATA; bc = '0; hf = 0; sh = pbuf[0];
            end
            S_R_RESTART: if (ev_ok) begin nst = S_R_DEVR; bc = '0; hf = 0; sh = devw | 8'd1; end
                         else if (ev_bad) begin err_r <= ST_RESTART_ERR; nst = S_STOP; bc = '0; hf = 0; sh = '0; end
            S_R_DEVR: if (ev_ok) begin nst = S_R_DATA; bc = '0; hf = 0; sh = '0; end
                      else if (ev_bad) begin err_r <= ST_READ_NACK; nst = S_STOP; bc = '0; hf = 0; sh = '0; end
            S_R_DATA: if (ev_byte) begin
              if (mode_r == M_READ) begin
                if (left_r != '0) left = left_r - 9'd1;
                r.rvalid = 1'b1; r.rbyte = sh; r.rlast = left == '0;
              end else begin
                pbuf[xi_r[3:0]] <= sh; xi_r <= xi_r + 5'd1;
              end
            end else if (ev_ok) begin
              nst = last ? S_STOP : S_R_DATA; bc = '0; hf = 0; sh = '0;
            end
            S_W_DATA: if (ev_ok) begin
              xi_r <= xi_r + 5'd1; bc = '0; hf = 0;
              if (xi_r != 5'(PageBytes - 1)) begin
                nst = S_W_DATA; sh = pbuf[xi_r[3:0] + 4'd1];
              end else begin nst = S_STOP; sh = '0; end
            end else if (ev_bad) begin
              err_r <= ST_DATA_NACK; nst = S_STOP; bc = '0; hf = 0; sh = '0;
            end
            default: ;
          endcase
          // Completion of STOP or WAIT.
          if ((st_r == S_STOP || st_r == S_WAIT) && ev_ok) begin
            w = (mode_r == M_PGWR) ? wwait_r : {4'd0, rwait_r};
            bc = '0; hf = 0; sh = '0;
            if (st_r == S_STOP && err_r != ST_OK && mode_r != M_PGRD) begin
              nst = S_IDLE; r.done = 1'b1; r.status = err_r;
            end else if (st_r == S_STOP && err_r == ST_OK && w != '0) begin
              wait_r <= w; nst = S_WAIT;
            end else if (mode_r == M_PGRD) begin
              n = 5'(PageBytes) - {1'b0, poff_r};
              if ({4'd0, n} > left_r) n = left_r[4:0];
              left = left_r - {4'd0, n};
              mrg_r <= n; mode_r <= M_PGWR; err_r <= '0; xi_r <= '0;
              nst = (n == '0) ? S_W_START : S_MERGE;
              rd_phase_r <= 1'b0;
            end else if (mode_r == M_PGWR && left_r != '0) begin
              a = cur_r + 13'(PageBytes);
              cur_r <= a; poff_r <= '0;
              mode_r <= M_PGRD; xi_r <= '0; err_r <= '0; nst = S_R_START;
            end else begin
              nst = S_IDLE; r.done = 1'b1;
            end
          end
          scl_r <= c; sda_r <= d;
        end
        st_r <= nst; bc_r <= bc; half_r <= hf; sh_r <= sh; left_r <= left;
        r.scl = (it.op == OP_TICK) ? c : scl_r;
        r.sda = (it.op == OP_TICK) ? d : sda_r;
        r.busy = nst != S_IDLE;
        res <= r;
        res_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_merge_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_MERGE |-> !it_take) else $error("item taken during merge");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.done |-> !res.busy) else $error("done while busy");
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.done |-> res.status == ST_OK) else $error("status without done");
`endif

endmodule

@@ hdl/i2c_eeprom_page_master.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in_       in_push / in_full     in_op, in_sda_in, in_mem_address, in_byte_count, in_data_byte
// out_      out_pop / out_empty   out_scl_out ... out_busy_res
// cfg_      cfg_valid / cfg_ready cfg_index, cfg_data
// One item per cycle sustained while the engine is not merging and the result queue has room;
// each item yields one result. After a page read, buffered bytes are merged one at a time
// through the single write-buffer read port; no item is taken then and the input queue fills.
// Reset is synchronous on rst_n and needs no clearing pass.
// A full result queue stalls the engine; the input queue then fills.
module i2c_eeprom_page_master
  import iepm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic        in_sda_in,
  input  logic [12:0] in_mem_address,
  input  logic [8:0]  in_byte_count,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_read_last,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic        out_busy_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  item_t in_item, q_item;
  logic  q_empty, take, rv, rq_full, rq_empty;
  res_t  er, oq;

  assign cfg_ready = 1'b1;
  assign in_item = '{op: op_t'(in_op), sda: in_sda_in, addr: in_mem_address,
                     count: in_byte_count, data: in_data_byte};

  iepm_fifo #(.Width($bits(item_t))) u_inq (
    .clk, .rst_n, .wr(in_push), .wdata(in_item), .full(in_full),
    .rd(take), .rdata(q_item), .empty(q_empty));

  iepm_engine u_eng (
    .clk, .rst_n, .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .it_valid(!q_empty), .it(q_item), .it_take(take),
    .res_valid(rv), .res(er), .res_full(rq_full));

  // Room for the result in flight keeps the engine from overrunning.
  logic oq_full;
  iepm_fifo #(.Width($bits(res_t))) u_outq (
    .clk, .rst_n, .wr(rv), .wdata(er), .full(oq_full),
    .rd(out_pop), .rdata(oq), .empty(rq_empty));
  assign rq_full = oq_full || (rv && !(out_pop && !rq_empty)) && !rq_empty;

  assign out_empty      = rq_empty;
  assign out_scl_out    = oq.scl;
  assign out_sda_out    = oq.sda;
  assign out_read_valid = oq.rvalid;
  assign out_read_byte  = oq.rbyte;
  assign out_read_last  = oq.rlast;
  assign out_done_res   = oq.done;
  assign out_status     = oq.status;
  assign out_busy_res   = oq.busy;

endmodule
